// ===== rtl/assert_macros.svh =====
// assertion helpers used by the duplicate filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AST_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AST_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pdup_pkg.sv =====
`default_nettype none
package pdup_pkg;

  localparam int ADDR_W    = 32;
  localparam int ID_W      = 16;
  localparam int KEY_W     = ADDR_W + ID_W;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/pdup_key_store.sv =====
`default_nettype none
module pdup_key_store #(
  parameter int DEPTH = pdup_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [pdup_pkg::KEY_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [pdup_pkg::KEY_W-1:0] wr_data
);
  import pdup_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/packet_duplicate_filter.sv =====
// channel | ports                                        | direction
// --------+----------------------------------------------+----------
// in      | in_valid, in_ready, in_source_address,       | to block
//         | in_packet_id                                 |
// out     | out_valid, out_ready, out_is_duplicate       | from block
//
// one word at a time: the key is compared against the ring store one entry
// per cycle through the single read port, so every entry is scanned
// between acceptance of a word and its loaded result.
// the next word is taken while a result still waits in the output register.
// reset sets no store entries: entries not yet written since reset read as
// zero through the write pointer and a wrapped flag, so there is no clearing pass.
// a stalled output holds the finished word before the key is stored.
`default_nettype none
`include "assert_macros.svh"
module packet_duplicate_filter #(
  parameter int DEPTH = pdup_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pdup_pkg::ADDR_W-1:0] in_source_address,
  input  logic [pdup_pkg::ID_W-1:0]   in_packet_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_duplicate
);
  import pdup_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t           state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] q_idx_r;
  logic             q_vld_r;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] wp_r, wp_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_dup_r, out_dup_nxt;

  logic             in_acc;
  logic             rd_en;
  logic             wr_en;
  logic [KEY_W-1:0] rd_data;
  logic [KEY_W-1:0] entry;
  logic             entry_written;

  pdup_key_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (key_r)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign rd_en    = (state_r == ST_SCAN);

  // unless wrapped, entries at or past the write pointer have not been written since reset and read as zero
  assign entry_written = wrapped_r || (q_idx_r < wp_r);
  assign entry         = entry_written ? rd_data : '0;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    out_valid_nxt = out_valid_r;
    out_dup_nxt   = out_dup_r;
    wr_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (q_vld_r && (entry == key_r)) begin
      hit_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt    = {in_source_address, in_packet_id};
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        // last read data compared this cycle
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = hit_r;
          if (!hit_r) begin
            wr_en = 1'b1;
            if (wp_r == LAST_IDX) begin
              wp_nxt      = '0;
              wrapped_nxt = 1'b1;
            end else begin
              wp_nxt = wp_r + 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_vld_r     <= 1'b0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_vld_r     <= rd_en;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    q_idx_r   <= rd_idx_r;
    hit_r     <= hit_nxt;
    out_dup_r <= out_dup_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;

  `AST_CHK(a_accept_starts_scan, clk, rst_n,
           in_acc |=> (state_r == ST_SCAN && rd_idx_r == '0),
           "accepted word did not start a scan at entry zero")
  `AST_CHK(a_hit_sticks, clk, rst_n,
           (state_r == ST_SCAN && hit_r) |=> hit_r,
           "match lost during scan")
  `AST_CHK(a_wp_moves_on_store, clk, rst_n,
           !$stable(wp_r) |-> $past(wr_en),
           "write pointer moved without a store")
  `AST_ALL(a_no_read_write_overlap, clk,
           !(rd_en && wr_en),
           "store read and written in the same cycle")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pdup_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_WORDS = 440;
  localparam int HOLD_CYCLES  = 700;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HISTORY_LEN  = 160;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    bit                fixed;
    bit                dup;
  } dir_row_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    bit               dup;
  } verdict_t;

  // fixed verdicts only where the store contents are obvious
  localparam dir_row_t DIR_ROWS [14] = '{
    '{32'h0000_0000, 16'h0000, 1'b1, 1'b1},  // zero key hits the unwritten store, which reads as zero
    '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1},
    '{32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0},
    '{32'h0000_0000, 16'hFFFF, 1'b1, 1'b0},
    '{32'h0000_0000, 16'h0001, 1'b1, 1'b0},
    '{32'h0000_0001, 16'h0000, 1'b1, 1'b0},
    '{32'h0000_0000, 16'h0000, 1'b1, 1'b1},
    '{32'h8000_0000, 16'h8000, 1'b1, 1'b0},
    '{32'h8000_0000, 16'h8000, 1'b1, 1'b1},
    '{32'h1234_5678, 16'hABCD, 1'b0, 1'b0},
    '{32'h1234_5678, 16'hABCC, 1'b0, 1'b0},
    '{32'h1234_5678, 16'hABCD, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] in_source_address = '0;
  logic [ID_W-1:0]   in_packet_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_is_duplicate;

  logic [KEY_W-1:0] seen_store [DEPTH] = '{default: '0};
  int               seen_wptr = 0;
  verdict_t         pending_verdicts[$];
  logic [KEY_W-1:0] key_history[$];
  int               fail_count = 0;
  int               results_seen = 0;
  int               cycle_count = 0;
  int               burst_left = 0;

  packet_duplicate_filter #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_address(in_source_address),
    .in_packet_id     (in_packet_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_duplicate (out_is_duplicate)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("packet_duplicate_filter verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // ring store of seen keys, oldest entry overwritten once full
  function automatic bit predict_dedup(input logic [KEY_W-1:0] key);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      if (seen_store[i] == key) hit = 1'b1;
    if (!hit) begin
      seen_store[seen_wptr] = key;
      seen_wptr = (seen_wptr == DEPTH - 1) ? 0 : seen_wptr + 1;
    end
    return hit;
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic [ADDR_W-1:0] addr, input logic [ID_W-1:0] id,
                           input bit fixed, input bit fixed_dup);
    verdict_t v;
    bit hit;
    in_valid          <= 1'b1;
    in_source_address <= addr;
    in_packet_id      <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v.key = {addr, id};
    hit   = predict_dedup(v.key);
    v.dup = fixed ? fixed_dup : hit;
    pending_verdicts.push_back(v);
    key_history.push_back(v.key);
    if (key_history.size() > HISTORY_LEN) void'(key_history.pop_front());
  endtask

  // bursts of random length, gaps of random length, some bursts run together
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 7);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k   = {$urandom(), 16'($urandom_range(0, 65535))};
    if (key_history.size() == 0) return k;
    if (sel < 40) begin
      // recent keys still stored, older ones already evicted
      k = key_history[$urandom_range(0, key_history.size() - 1)];
    end else if (sel < 60) begin
      k = key_history[$urandom_range(0, key_history.size() - 1)];
      k = k ^ (48'h1 << $urandom_range(0, KEY_W - 1));
    end else if (sel < 66) begin
      k = '0;
    end else if (sel < 72) begin
      k[KEY_W-1:ID_W] = key_history[$urandom_range(0, key_history.size() - 1)][KEY_W-1:ID_W];
    end
    return k;
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIR_ROWS[i]) begin
      send_word(DIR_ROWS[i].addr, DIR_ROWS[i].id, DIR_ROWS[i].fixed, DIR_ROWS[i].dup);
      sender_gap();
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      k = pick_key();
      send_word(k[KEY_W-1:ID_W], k[ID_W-1:0], 1'b0, 1'b0);
      sender_gap();
    end
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0)
      $display("packet_duplicate_filter verification clean");
    else
      $display("packet_duplicate_filter verification failed");
    $finish;
  end

  initial begin : receiver
    int mode;
    int span;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      // one long hold-off so the block fills and stops taking words
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %0d with no word outstanding", results_seen));
      end else begin
        v = pending_verdicts.pop_front();
        if (out_is_duplicate !== v.dup)
          report_mismatch($sformatf("key %012h: is_duplicate %b, want %b",
                                    v.key, out_is_duplicate, v.dup));
      end
    end
  end

endmodule
